@@ hdl/huffman_bit_pack_encoder_macros.svh @@
// Assertion helpers used by the encoder RTL; clocked on clk, quiet while rst_n is low.
`ifndef HUFFMAN_BIT_PACK_ENCODER_MACROS_SVH
`define HUFFMAN_BIT_PACK_ENCODER_MACROS_SVH

// Same-cycle implication.
`define HBP_ASSERT_NOW(label, cond, check, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (check)) \
        else $error(msg);

// Implication checked in the next cycle.
`define HBP_ASSERT_NEXT(label, cond, check, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (check)) \
        else $error(msg);

`endif

@@ hdl/hbp_pkg.sv @@
package hbp_pkg;

    localparam int MAX_CODE_LEN = 32;
    localparam int SYMBOL_COUNT = 256;

    localparam int SYM_W     = 8;
    localparam int WORD_W    = 32;
    localparam int LEN_W     = 6;
    localparam int BYTE_W    = 8;
    localparam int PEND_W    = 7;
    localparam int PCNT_W    = 3;
    localparam int CNT_W     = 3;
    localparam int MAX_BYTES = 4;

    localparam int CODE_LIM = (MAX_CODE_LEN < WORD_W) ? MAX_CODE_LEN : WORD_W;
    localparam int TABLE_AW = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int ENTRY_W  = LEN_W + WORD_W;
    localparam int ACC_W    = PEND_W + WORD_W;

    typedef enum logic [1:0] {
        MODE_LOAD   = 2'd0,
        MODE_ENCODE = 2'd1,
        MODE_FLUSH  = 2'd2
    } mode_t;

    typedef logic [MAX_BYTES-1:0][BYTE_W-1:0] byte_vec_t;

    // Outcome of one item at the packing stage.
    typedef struct packed {
        logic [CNT_W-1:0]  count;
        byte_vec_t         bytes;
        logic              upd;
        logic [PEND_W-1:0] pend;
        logic [PCNT_W-1:0] pcnt;
    } pack_res_t;

endpackage

@@ hdl/hbp_ram.sv @@
module hbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/hbp_pack.sv @@
module hbp_pack (
    input  logic [1:0]                  mode,
    input  logic [hbp_pkg::LEN_W-1:0]   len,
    input  logic [hbp_pkg::WORD_W-1:0]  word,
    input  logic [hbp_pkg::PEND_W-1:0]  pend,
    input  logic [hbp_pkg::PCNT_W-1:0]  pcnt,
    output hbp_pkg::pack_res_t          res
);

    import hbp_pkg::*;

    logic [ACC_W-1:0]  acc;
    logic [ACC_W:0]    left;
    logic [LEN_W-1:0]  total;
    logic [2:0]        rem;
    logic [BYTE_W-1:0] flush_byte;

    always_comb
    begin
        // Append the code after the pending bits, then left-justify so bytes
        // sit at fixed slices.
        acc        = (ACC_W'(pend) << len) | ACC_W'(word);
        total      = LEN_W'(pcnt) + len;
        rem        = total[2:0];
        left       = {1'b0, acc} << (LEN_W'(ACC_W + 1) - total);
        flush_byte = BYTE_W'({1'b0, pend}) << (4'(BYTE_W) - 4'(pcnt));

        res = '0;
        case (mode)
            MODE_ENCODE:
            begin
                if (len != '0)
                begin
                    res.upd   = 1'b1;
                    res.count = CNT_W'(total >> 3);
                    for (int i = 0; i < MAX_BYTES; i++)
                    begin
                        res.bytes[i] = left[ACC_W - BYTE_W*i -: BYTE_W];
                    end
                    res.pend = acc[PEND_W-1:0] & PEND_W'((8'd1 << rem) - 8'd1);
                    res.pcnt = rem;
                end
            end
            MODE_FLUSH:
            begin
                if (pcnt != '0)
                begin
                    res.upd      = 1'b1;
                    res.count    = CNT_W'(1);
                    res.bytes[0] = flush_byte;
                end
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

endmodule

@@ hdl/huffman_bit_pack_encoder.sv @@
// Huffman encoder with an MSB-first bit packer.
// Input channel sym_valid/sym_ready carries mode, symbol, code_word, code_length.
// mode load writes one table entry (length clamped, upper code bits dropped);
// mode encode appends the symbol's code after the pending bits; mode flush
// emits the pending bits as one byte padded with zeros. Output channel
// byte_valid/byte_ready carries out_byte and last_of_run, which marks the last
// byte caused by one input item; items that cause no byte give no output.
// An accepted item and its table read are registered in the packing stage; its
// bytes then enter the output register once that register is free.
// Throughput: one item per cycle while each item yields at most one byte and
// the receiver takes every byte; an item that yields n bytes holds the output
// register until all n drain, at one byte per cycle while byte_ready is high.
// Reset clears the pending bits and a flag per table entry at once, so every
// symbol reads as length zero until loaded; no clearing pass is needed.
// When the receiver stalls the output register holds its byte, the packing
// stage holds its item and sym_ready drops; nothing is lost.
module huffman_bit_pack_encoder (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         sym_valid,
    output logic                         sym_ready,
    input  logic [1:0]                   mode,
    input  logic [hbp_pkg::SYM_W-1:0]    symbol,
    input  logic [hbp_pkg::WORD_W-1:0]   code_word,
    input  logic [hbp_pkg::LEN_W-1:0]    code_length,
    output logic                         byte_valid,
    input  logic                         byte_ready,
    output logic [hbp_pkg::BYTE_W-1:0]   out_byte,
    output logic                         last_of_run
);

    import hbp_pkg::*;

    `include "huffman_bit_pack_encoder_macros.svh"

    logic                in_acc;
    logic                in_table;
    logic [TABLE_AW-1:0] tab_addr;
    logic [LEN_W-1:0]    len_clamp;
    logic [WORD_W:0]     one_sh;
    logic [WORD_W-1:0]   word_mask;
    logic                tab_we;
    logic [ENTRY_W-1:0]  tab_rdata;

    logic [SYMBOL_COUNT-1:0] loaded_reg;

    // Packing stage
    logic             s1_valid_reg;
    logic [1:0]       s1_mode_reg;
    logic             s1_hit_reg;
    logic [LEN_W-1:0] len_eff;
    pack_res_t        res;
    logic             s1_adv;

    // Pending bits
    logic [PEND_W-1:0] pend_reg;
    logic [PCNT_W-1:0] pcnt_reg;

    // Output register: up to four bytes, byte 0 presented
    byte_vec_t         buf_reg;
    byte_vec_t         buf_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              take;
    logic              buf_free;

    assign in_acc   = sym_valid && sym_ready;
    assign in_table = ({1'b0, symbol} < (SYM_W + 1)'(SYMBOL_COUNT));
    assign tab_addr = symbol[TABLE_AW-1:0];

    // Clamp the length and drop code bits above it before storing.
    always_comb
    begin
        len_clamp = (code_length > LEN_W'(CODE_LIM)) ? LEN_W'(CODE_LIM) : code_length;
        one_sh    = (WORD_W + 1)'(1) << len_clamp;
        word_mask = WORD_W'(one_sh - (WORD_W + 1)'(1));
    end

    assign tab_we = in_acc && (mode == MODE_LOAD) && in_table;

    hbp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SYMBOL_COUNT)
    ) u_table (
        .clk   (clk),
        .we    (tab_we),
        .waddr (tab_addr),
        .wdata ({len_clamp, code_word & word_mask}),
        .re    (in_acc),
        .raddr (tab_addr),
        .rdata (tab_rdata)
    );

    // An entry never loaded reads as length zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg <= '0;
        end
        else if (tab_we)
        begin
            loaded_reg[tab_addr] <= 1'b1;
        end
    end

    // The output register can take a new item if empty or draining its last byte.
    assign take      = byte_valid && byte_ready;
    assign buf_free  = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && byte_ready);
    assign s1_adv    = s1_valid_reg && buf_free;
    assign sym_ready = !s1_valid_reg || buf_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_mode_reg  <= '0;
            s1_hit_reg   <= 1'b0;
        end
        else if (in_acc)
        begin
            s1_valid_reg <= 1'b1;
            s1_mode_reg  <= mode;
            s1_hit_reg   <= in_table && loaded_reg[tab_addr];
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    assign len_eff = s1_hit_reg ? tab_rdata[ENTRY_W-1:WORD_W] : '0;

    hbp_pack u_pack (
        .mode (s1_mode_reg),
        .len  (len_eff),
        .word (tab_rdata[WORD_W-1:0]),
        .pend (pend_reg),
        .pcnt (pcnt_reg),
        .res  (res)
    );

    // Advance the pending bits only when the item moves on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            pcnt_reg <= '0;
        end
        else if (s1_adv && res.upd)
        begin
            pend_reg <= res.pend;
            pcnt_reg <= res.pcnt;
        end
    end

    // Load a fresh run, or drop the byte just taken and shift the rest down.
    always_comb
    begin
        buf_next = buf_reg;
        cnt_next = cnt_reg;
        if (s1_adv)
        begin
            buf_next = res.bytes;
            cnt_next = res.count;
        end
        else if (take)
        begin
            buf_next = buf_reg >> BYTE_W;
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

    assign byte_valid  = (cnt_reg != '0);
    assign out_byte    = buf_reg[0];
    assign last_of_run = (cnt_reg == CNT_W'(1));

    `HBP_ASSERT_NOW(a_cnt_range, 1'b1, cnt_reg <= CNT_W'(MAX_BYTES), "byte count beyond four")
    `HBP_ASSERT_NEXT(a_run_continues, take && (cnt_reg > CNT_W'(1)), byte_valid,
        "run of bytes broken before its last byte")
    `HBP_ASSERT_NEXT(a_flush_clears, s1_adv && (s1_mode_reg == MODE_FLUSH), pcnt_reg == '0,
        "pending bits left after flush")

endmodule

@@ bench/tb_huffman_bit_pack_encoder.sv @@
`timescale 1ns / 1ps

module tb_huffman_bit_pack_encoder;
    import hbp_pkg::*;

    // The spare mode code: the block must ignore it.
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam int RANDOM_ITEMS = 245;
    localparam int HOT_SYMS     = 16;
    localparam int MAX_GAP      = 13;
    localparam int HOLD_AT_ITEM = 110;
    localparam int HOLD_CYCLES  = 250;
    localparam int DRAIN_CYCLES = 24;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int REPORT_MAX   = 10;

    typedef struct {
        logic [1:0]        mode;
        logic [SYM_W-1:0]  symbol;
        logic [WORD_W-1:0] code_word;
        logic [LEN_W-1:0]  code_length;
    } sym_item_t;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              last;
    } packed_byte_t;

    // Clock, reset and block ports; every input is known from time zero.
    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              sym_valid = 1'b0;
    logic              sym_ready;
    logic [1:0]        mode = MODE_LOAD;
    logic [SYM_W-1:0]  symbol = '0;
    logic [WORD_W-1:0] code_word = '0;
    logic [LEN_W-1:0]  code_length = '0;
    logic              byte_valid;
    logic              byte_ready = 1'b0;
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_run;

    // Items waiting to be offered, and bytes the packer model says must come out.
    sym_item_t    item_queue[$];
    packed_byte_t expected_bytes[$];

    // Private copy of the code table and the bit accumulator.
    logic [WORD_W-1:0] code_bits [SYMBOL_COUNT];
    logic [LEN_W-1:0]  code_len  [SYMBOL_COUNT];
    logic [PEND_W-1:0] held_bits;
    logic [PCNT_W-1:0] held_count;

    // Handshake flags, written at the rising edge, read at the falling edge; rx_hold is written at the falling edge.
    logic in_taken  = 1'b0;
    logic out_taken = 1'b0;
    logic rx_hold   = 1'b0;

    int items_total;
    int items_directed;
    int items_taken;
    int bytes_checked;
    int mismatches;
    int cycles;
    int tx_gap;
    int rx_stall;
    bit tx_quiet;
    bit rx_quiet;
    int hold_count;
    bit hold_done;

    huffman_bit_pack_encoder u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .sym_valid   (sym_valid),
        .sym_ready   (sym_ready),
        .mode        (mode),
        .symbol      (symbol),
        .code_word   (code_word),
        .code_length (code_length),
        .byte_valid  (byte_valid),
        .byte_ready  (byte_ready),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

    always #2 clk = ~clk;

    function automatic logic [63:0] low_bits(input int n);
        return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    endfunction

    // Run one accepted item through the packer model and queue the bytes it yields.
    task automatic pack_item(input sym_item_t it);
        logic [LEN_W-1:0]  len;
        logic [63:0]       acc;
        logic [BYTE_W-1:0] made [MAX_BYTES];
        int                total;
        int                n;
        packed_byte_t      pb;
        n = 0;
        case (it.mode)
            MODE_LOAD:
            begin
                if (it.symbol < SYMBOL_COUNT)
                begin
                    // Clamp the length, drop code bits above it.
                    len = (it.code_length > CODE_LIM) ? LEN_W'(CODE_LIM) : it.code_length;
                    code_len[it.symbol]  = len;
                    code_bits[it.symbol] = WORD_W'(64'(it.code_word) & low_bits(len));
                end
            end
            MODE_ENCODE:
            begin
                len = (it.symbol < SYMBOL_COUNT) ? code_len[it.symbol] : '0;
                if (len != 0)
                begin
                    acc   = (64'(held_bits) << len) | (64'(code_bits[it.symbol]) & low_bits(len));
                    total = held_count + len;
                    while (total >= BYTE_W && n < MAX_BYTES)
                    begin
                        total   -= BYTE_W;
                        made[n] = BYTE_W'(acc >> total);
                        n++;
                    end
                    held_bits  = PEND_W'(acc & low_bits(total));
                    held_count = PCNT_W'(total);
                end
            end
            MODE_FLUSH:
            begin
                if (held_count != 0)
                begin
                    // Pad the pending bits with zeros at the low end.
                    made[0]    = BYTE_W'(16'(held_bits) << (BYTE_W - int'(held_count)));
                    n          = 1;
                    held_bits  = '0;
                    held_count = '0;
                end
            end
            default: ;
        endcase
        for (int i = 0; i < n; i++)
        begin
            pb = '{data: made[i], last: (i == n - 1)};
            expected_bytes.insert(expected_bytes.size(), pb);
        end
    endtask

    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("%s", msg);
    endtask

    task automatic add_item(input logic [1:0] m, input logic [SYM_W-1:0] s,
                            input logic [WORD_W-1:0] w, input logic [LEN_W-1:0] l);
        sym_item_t it;
        it = '{mode: m, symbol: s, code_word: w, code_length: l};
        item_queue.insert(item_queue.size(), it);
    endtask

    // Pick a load length: mostly short codes, some long, some over the limit, a few zero.
    function automatic logic [LEN_W-1:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return LEN_W'($urandom_range(1, 12));
        else if (r < 85)
            return LEN_W'($urandom_range(13, 32));
        else if (r < 95)
            return LEN_W'($urandom_range(33, 63));
        return '0;
    endfunction

    // Check output bytes and model each input item at the rising edge.
    always @(posedge clk)
    begin
        packed_byte_t want;
        if (rst_n)
        begin
            if (byte_valid && byte_ready)
            begin
                bytes_checked++;
                if (expected_bytes.size() == 0)
                    flag_mismatch($sformatf("unexpected byte %02h last %0b",
                                            out_byte, last_of_run));
                else
                begin
                    want = expected_bytes.pop_front();
                    if (want.data !== out_byte || want.last !== last_of_run)
                        flag_mismatch($sformatf(
                            "byte %0d: expected %02h last %0b, got %02h last %0b",
                            bytes_checked, want.data, want.last, out_byte, last_of_run));
                end
            end
            // Output can never belong to an item taken at the same edge, so order is safe.
            if (sym_valid && sym_ready)
            begin
                pack_item('{mode: mode, symbol: symbol, code_word: code_word,
                            code_length: code_length});
                items_taken++;
            end
            in_taken  <= sym_valid && sym_ready;
            out_taken <= byte_valid && byte_ready;
        end
    end

    // Sender: hold the item until taken, then wait its drawn gap and offer the next.
    always @(negedge clk)
    begin
        sym_item_t nxt;
        logic      valid_n;
        if (rst_n)
        begin
            valid_n = sym_valid;
            if (!sym_valid || in_taken)
            begin
                valid_n = 1'b0;
                if (tx_gap > 0)
                    tx_gap--;
                else if (item_queue.size() != 0)
                begin
                    nxt         = item_queue.pop_front();
                    mode        <= nxt.mode;
                    symbol      <= nxt.symbol;
                    code_word   <= nxt.code_word;
                    code_length <= nxt.code_length;
                    valid_n     = 1'b1;
                    tx_gap      = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
                    // Switch now and then between gappy and back-to-back stretches.
                    if ($urandom_range(0, 29) == 0)
                        tx_quiet = !tx_quiet;
                end
            end
            sym_valid <= valid_n;
        end
    end

    // Receiver: stall a drawn number of cycles before each byte, or hold off entirely.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_taken)
            begin
                rx_stall = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
                if ($urandom_range(0, 29) == 0)
                    rx_quiet = !rx_quiet;
            end
            if (rx_hold)
                byte_ready <= 1'b0;
            else if (rx_stall > 0)
            begin
                rx_stall--;
                byte_ready <= 1'b0;
            end
            else
                byte_ready <= 1'b1;
        end
    end

    // Long hold-off on the output side, once, part-way through the run.
    // The sender keeps offering, so the block fills and drops sym_ready.
    always @(negedge clk)
    begin
        if (rst_n && !hold_done && items_taken >= HOLD_AT_ITEM)
        begin
            if (hold_count < HOLD_CYCLES)
            begin
                rx_hold <= 1'b1;
                hold_count++;
            end
            else
            begin
                rx_hold   <= 1'b0;
                hold_done = 1'b1;
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        logic [SYM_W-1:0] hot [HOT_SYMS];
        int               r;
        for (int i = 0; i < SYMBOL_COUNT; i++)
        begin
            code_bits[i] = '0;
            code_len[i]  = '0;
        end
        held_bits  = '0;
        held_count = '0;

        // Directed part: empty table, empty flush, spare mode, length clamp,
        // dropped code bits, zero length, longest codes with the most pending bits.
        add_item(MODE_ENCODE, 8'h41, 32'h0,        6'd0);
        add_item(MODE_FLUSH,  8'h00, 32'h0,        6'd0);
        add_item(MODE_SPARE,  8'hff, 32'hffffffff, 6'd63);
        add_item(MODE_LOAD,   8'h00, 32'hffffffff, 6'd32);
        add_item(MODE_LOAD,   8'hff, 32'hffffffff, 6'd1);
        add_item(MODE_LOAD,   8'h01, 32'h12345678, 6'd63);
        add_item(MODE_LOAD,   8'h02, 32'ha5a5a5a5, 6'd33);
        add_item(MODE_LOAD,   8'h03, 32'h000000ff, 6'd0);
        add_item(MODE_LOAD,   8'h04, 32'hffffff55, 6'd7);
        add_item(MODE_LOAD,   8'h05, 32'h000000a5, 6'd8);
        add_item(MODE_ENCODE, 8'hff, 32'h0,        6'd0);
        add_item(MODE_ENCODE, 8'h00, 32'hffffffff, 6'd63);
        add_item(MODE_ENCODE, 8'h04, 32'h0,        6'd0);
        add_item(MODE_ENCODE, 8'h03, 32'h0,        6'd0);
        add_item(MODE_FLUSH,  8'h00, 32'h0,        6'd0);
        add_item(MODE_ENCODE, 8'h04, 32'h0,        6'd0);
        add_item(MODE_ENCODE, 8'h00, 32'h0,        6'd0);
        add_item(MODE_SPARE,  8'h00, 32'h0,        6'd0);
        add_item(MODE_LOAD,   8'h06, 32'h00000003, 6'd2);
        add_item(MODE_ENCODE, 8'h06, 32'h0,        6'd0);
        add_item(MODE_FLUSH,  8'hff, 32'hffffffff, 6'd63);
        add_item(MODE_ENCODE, 8'h01, 32'h0,        6'd0);
        add_item(MODE_ENCODE, 8'h02, 32'h0,        6'd0);
        add_item(MODE_ENCODE, 8'h05, 32'h0,        6'd0);
        add_item(MODE_LOAD,   8'h00, 32'h00000000, 6'd1);
        add_item(MODE_ENCODE, 8'h00, 32'h0,        6'd0);
        add_item(MODE_FLUSH,  8'h00, 32'h0,        6'd0);
        items_directed = item_queue.size();

        // Random part: load a small alphabet first so encodes mostly hit live codes.
        for (int i = 0; i < HOT_SYMS; i++)
        begin
            hot[i] = SYM_W'($urandom_range(0, 255));
            add_item(MODE_LOAD, hot[i], $urandom, LEN_W'($urandom_range(1, 12)));
        end
        for (int i = HOT_SYMS; i < RANDOM_ITEMS; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                add_item(MODE_ENCODE, hot[$urandom_range(0, HOT_SYMS - 1)], $urandom,
                         LEN_W'($urandom));
            else if (r < 63)
                add_item(MODE_ENCODE, SYM_W'($urandom), $urandom, LEN_W'($urandom));
            else if (r < 78)
            begin
                if ($urandom_range(0, 9) < 7)
                    add_item(MODE_LOAD, hot[$urandom_range(0, HOT_SYMS - 1)], $urandom,
                             pick_length());
                else
                    add_item(MODE_LOAD, SYM_W'($urandom), $urandom, pick_length());
            end
            else if (r < 93)
                add_item(MODE_FLUSH, SYM_W'($urandom), $urandom, LEN_W'($urandom));
            else
                add_item(MODE_SPARE, SYM_W'($urandom), $urandom, LEN_W'($urandom));
        end
        items_total = item_queue.size();

        // Hold reset, then release it on a falling edge.
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Wait for every item to be taken and every byte to arrive, then drain.
        while (items_taken < items_total || expected_bytes.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        mismatches += expected_bytes.size();

        $display("Run covered %0d items (%0d directed), %0d output bytes checked",
                 items_total, items_directed, bytes_checked);
        $display("Receiver held off %0d cycles in one stretch; %0d mismatches",
                 hold_count, mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hdl
hdl/hbp_pkg.sv
hdl/hbp_ram.sv
hdl/hbp_pack.sv
hdl/huffman_bit_pack_encoder.sv
bench/tb_huffman_bit_pack_encoder.sv
